>>> src/rar_pkg.sv
// ---------------------------------------------------------------------------
// rar_pkg: shared definitions for the rational adder
// Widths of the fraction fields and the product path, and the request and
// response groups of the shared divide unit.
// ---------------------------------------------------------------------------
package rar_pkg;

   // Width of each incoming numerator and denominator.
   localparam int IN_WIDTH = 16;

   // Products and every value that the divide unit sees.
   localparam int PROD_W = 2 * IN_WIDTH;

   // Fixed widths of the result fields.
   localparam int SUM_NUM_W = 32;
   localparam int SUM_DEN_W = 30;

   // Working width when the result fields are formed from a product-wide value.
   localparam int EXT_W = (PROD_W > SUM_NUM_W) ? PROD_W : SUM_NUM_W;

   // Step counter of the divide unit, one quotient bit per cycle.
   localparam int DIV_CNT_W = $clog2(PROD_W);

   // Request to the divide unit.
   typedef struct packed {
      logic              start;
      logic [PROD_W-1:0] dividend;
      logic [PROD_W-1:0] divisor;
   } div_req_type;

   // Response from the divide unit.
   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] quotient;
      logic [PROD_W-1:0] remainder;
   } div_rsp_type;

endpackage

>>> src/rar_req_if.sv
// ---------------------------------------------------------------------------
// rar_req_if: request channel of the rational adder
// Carries two signed fractions with a valid/ready handshake.
// ---------------------------------------------------------------------------
interface rar_req_if import rar_pkg::*; ();

   logic                       valid;
   logic                       ready;
   logic signed [IN_WIDTH-1:0] num_a;
   logic signed [IN_WIDTH-1:0] den_a;
   logic signed [IN_WIDTH-1:0] num_b;
   logic signed [IN_WIDTH-1:0] den_b;

   modport source (output valid, output num_a, output den_a, output num_b,
                   output den_b, input ready);
   modport sink (input valid, input num_a, input den_a, input num_b,
                 input den_b, output ready);

endinterface

>>> src/rar_rsp_if.sv
// ---------------------------------------------------------------------------
// rar_rsp_if: response channel of the rational adder
// Carries the reduced sum and the error flag with a valid/ready handshake.
// ---------------------------------------------------------------------------
interface rar_rsp_if import rar_pkg::*; ();

   logic                        valid;
   logic                        ready;
   logic signed [SUM_NUM_W-1:0] sum_num;
   logic [SUM_DEN_W-1:0]        sum_den;
   logic                        bad_input;

   modport source (output valid, output sum_num, output sum_den,
                   output bad_input, input ready);
   modport sink (input valid, input sum_num, input sum_den,
                 input bad_input, output ready);

endinterface

>>> src/rar_div.sv
// ---------------------------------------------------------------------------
// rar_div: shared restoring divider
// Unsigned division of two product-wide values, one quotient bit per cycle.
// Gives quotient and remainder and pulses done in the cycle after the last step.
// ---------------------------------------------------------------------------
module rar_div import rar_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [PROD_W-1:0]    rem_ff, rem_in;
   logic [PROD_W-1:0]    quo_ff, quo_in;
   logic [PROD_W-1:0]    dsr_ff, dsr_in;
   logic [PROD_W:0]      shifted;
   logic [PROD_W:0]      trial;

   // Trial subtraction of the divisor from the shifted partial remainder.
   assign shifted = {rem_ff, quo_ff[PROD_W-1]};
   assign trial   = shifted - {1'b0, dsr_ff};

   // Step control: load on start, then one bit per cycle until the count ends.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (trial[PROD_W]) begin
            rem_in = shifted[PROD_W-1:0];
         end else begin
            rem_in = trial[PROD_W-1:0];
         end
         quo_in = {quo_ff[PROD_W-2:0], ~trial[PROD_W]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(PROD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

>>> src/rational_add_reduce.sv
// ---------------------------------------------------------------------------
// rational_add_reduce: sum of two fractions in lowest terms
// Moves each sign to its numerator, cross-multiplies on one multiplier,
// finds the greatest common divisor by Euclid's algorithm on a shared divider
// and divides numerator and denominator by it.
//
//   word      direction  handshake          contents
//   req_bus   in         valid / ready      num_a, den_a, num_b, den_b
//   rsp_bus   out        valid / ready      sum_num, sum_den, bad_input
//
// Each Euclid step is one full pass of the bit-serial divider, and the
// reductions of numerator and denominator take one pass each. A zero
// denominator or a zero sum skips the divider.
// Reset is synchronous and clears the sequencer and the response valid flag.
// A new word is taken only when the sequencer is idle; a stalled response
// holds in the output register and only the final transfer waits on it.
// ---------------------------------------------------------------------------
module rational_add_reduce import rar_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   rar_req_if.sink   req_bus,
   rar_rsp_if.source rsp_bus
);

   // Sequencer states.
   typedef enum logic [11:0] {
      ST_IDLE     = 12'b0000_0000_0001,
      ST_MUL_A    = 12'b0000_0000_0010,
      ST_MUL_B    = 12'b0000_0000_0100,
      ST_MUL_D    = 12'b0000_0000_1000,
      ST_SUM      = 12'b0000_0001_0000,
      ST_GCD      = 12'b0000_0010_0000,
      ST_GCD_WAIT = 12'b0000_0100_0000,
      ST_QN       = 12'b0000_1000_0000,
      ST_QN_WAIT  = 12'b0001_0000_0000,
      ST_QD       = 12'b0010_0000_0000,
      ST_QD_WAIT  = 12'b0100_0000_0000,
      ST_DONE     = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [IN_WIDTH-1:0]  na_ff, na_in, da_ff, da_in;
   logic [IN_WIDTH-1:0]  nb_ff, nb_in, db_ff, db_in;
   logic                 nega_ff, nega_in, negb_ff, negb_in;
   logic                 neg_ff, neg_in, bad_ff, bad_in;
   logic [PROD_W-1:0]    ta_ff, ta_in, tb_ff, tb_in;
   logic [PROD_W-1:0]    mag_ff, mag_in, den_ff, den_in;
   logic [PROD_W-1:0]    x_ff, x_in, y_ff, y_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SUM_NUM_W-1:0] rsp_num_ff, rsp_num_in;
   logic [SUM_DEN_W-1:0] rsp_den_ff, rsp_den_in;
   logic                 rsp_bad_ff, rsp_bad_in;

   logic                 req_take;
   logic [IN_WIDTH-1:0]  abs_na, abs_da, abs_nb, abs_db;
   logic [IN_WIDTH-1:0]  mul_x, mul_y;
   logic [PROD_W-1:0]    prod;
   logic [PROD_W-1:0]    sum_ab;
   logic [PROD_W:0]      diff_ab;
   logic [PROD_W-1:0]    mag_sel;
   logic                 neg_sel;
   logic [EXT_W-1:0]     mag_ext, num_ext, den_ext;
   div_req_type          div_req;
   div_rsp_type          div_rsp;

   // Magnitudes of the incoming fields; the most negative value maps exactly.
   assign abs_na = req_bus.num_a[IN_WIDTH-1] ? (~req_bus.num_a + 1'b1) : req_bus.num_a;
   assign abs_da = req_bus.den_a[IN_WIDTH-1] ? (~req_bus.den_a + 1'b1) : req_bus.den_a;
   assign abs_nb = req_bus.num_b[IN_WIDTH-1] ? (~req_bus.num_b + 1'b1) : req_bus.num_b;
   assign abs_db = req_bus.den_b[IN_WIDTH-1] ? (~req_bus.den_b + 1'b1) : req_bus.den_b;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;

   // The single multiplier, its operands chosen by the sequencer.
   always_comb begin
      unique case (state_ff)
         ST_MUL_A: begin
            mul_x = na_ff;
            mul_y = db_ff;
         end
         ST_MUL_B: begin
            mul_x = nb_ff;
            mul_y = da_ff;
         end
         default: begin
            mul_x = da_ff;
            mul_y = db_ff;
         end
      endcase
   end
   assign prod = mul_x * mul_y;

   // Signed sum of the two cross products as sign and magnitude.
   assign sum_ab  = ta_ff + tb_ff;
   assign diff_ab = {1'b0, ta_ff} - {1'b0, tb_ff};
   always_comb begin
      priority if (nega_ff == negb_ff) begin
         mag_sel = sum_ab;
         neg_sel = nega_ff;
      end else if (!diff_ab[PROD_W]) begin
         mag_sel = diff_ab[PROD_W-1:0];
         neg_sel = nega_ff;
      end else begin
         mag_sel = ~diff_ab[PROD_W-1:0] + 1'b1;
         neg_sel = negb_ff;
      end
   end

   // Result fields from the reduced magnitude and denominator.
   assign mag_ext = EXT_W'(mag_ff);
   assign num_ext = neg_ff ? (~mag_ext + 1'b1) : mag_ext;
   assign den_ext = EXT_W'(den_ff);

   // Requests to the shared divider: Euclid steps, then the two reductions.
   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = x_ff;
      div_req.divisor  = y_ff;
      unique case (state_ff)
         ST_GCD: begin
            div_req.start = (y_ff != '0);
         end
         ST_QN: begin
            div_req.start    = 1'b1;
            div_req.dividend = mag_ff;
            div_req.divisor  = x_ff;
         end
         ST_QD: begin
            div_req.start    = 1'b1;
            div_req.dividend = den_ff;
            div_req.divisor  = x_ff;
         end
         default: begin
            div_req.start = 1'b0;
         end
      endcase
   end

   rar_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Sequencer and datapath next values.
   always_comb begin
      state_in     = state_ff;
      na_in        = na_ff;
      da_in        = da_ff;
      nb_in        = nb_ff;
      db_in        = db_ff;
      nega_in      = nega_ff;
      negb_in      = negb_ff;
      neg_in       = neg_ff;
      bad_in       = bad_ff;
      ta_in        = ta_ff;
      tb_in        = tb_ff;
      mag_in       = mag_ff;
      den_in       = den_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;
      rsp_bad_in   = rsp_bad_ff;

      // The response register empties when the sink takes the word.
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               na_in   = abs_na;
               da_in   = abs_da;
               nb_in   = abs_nb;
               db_in   = abs_db;
               nega_in = (req_bus.num_a[IN_WIDTH-1] ^ req_bus.den_a[IN_WIDTH-1])
                         && (abs_na != '0);
               negb_in = (req_bus.num_b[IN_WIDTH-1] ^ req_bus.den_b[IN_WIDTH-1])
                         && (abs_nb != '0);
               neg_in  = 1'b0;
               if ((abs_da == '0) || (abs_db == '0)) begin
                  // A zero denominator gives zeros and the error flag.
                  bad_in   = 1'b1;
                  mag_in   = '0;
                  den_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  bad_in   = 1'b0;
                  state_in = ST_MUL_A;
               end
            end
         end
         ST_MUL_A: begin
            ta_in    = prod;
            state_in = ST_MUL_B;
         end
         ST_MUL_B: begin
            tb_in    = prod;
            state_in = ST_MUL_D;
         end
         ST_MUL_D: begin
            den_in   = prod;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            neg_in = neg_sel;
            if (mag_sel == '0) begin
               // A zero sum is given as 0/1.
               mag_in   = '0;
               den_in   = {{(PROD_W-1){1'b0}}, 1'b1};
               neg_in   = 1'b0;
               state_in = ST_DONE;
            end else begin
               mag_in   = mag_sel;
               x_in     = mag_sel;
               y_in     = den_ff;
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            // Once the remainder reaches zero, x holds the divisor.
            if (y_ff == '0) begin
               state_in = ST_QN;
            end else begin
               state_in = ST_GCD_WAIT;
            end
         end
         ST_GCD_WAIT: begin
            if (div_rsp.done) begin
               x_in     = y_ff;
               y_in     = div_rsp.remainder;
               state_in = ST_GCD;
            end
         end
         ST_QN: begin
            state_in = ST_QN_WAIT;
         end
         ST_QN_WAIT: begin
            if (div_rsp.done) begin
               mag_in   = div_rsp.quotient;
               state_in = ST_QD;
            end
         end
         ST_QD: begin
            state_in = ST_QD_WAIT;
         end
         ST_QD_WAIT: begin
            if (div_rsp.done) begin
               den_in   = div_rsp.quotient;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = num_ext[SUM_NUM_W-1:0];
               rsp_den_in   = den_ext[SUM_DEN_W-1:0];
               rsp_bad_in   = bad_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath and response payload registers.
   always_ff @(posedge clock) begin
      na_ff      <= na_in;
      da_ff      <= da_in;
      nb_ff      <= nb_in;
      db_ff      <= db_in;
      nega_ff    <= nega_in;
      negb_ff    <= negb_in;
      neg_ff     <= neg_in;
      bad_ff     <= bad_in;
      ta_ff      <= ta_in;
      tb_ff      <= tb_in;
      mag_ff     <= mag_in;
      den_ff     <= den_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      rsp_num_ff <= rsp_num_in;
      rsp_den_ff <= rsp_den_in;
      rsp_bad_ff <= rsp_bad_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.sum_num   = rsp_num_ff;
   assign rsp_bus.sum_den   = rsp_den_ff;
   assign rsp_bus.bad_input = rsp_bad_ff;

endmodule
